// ----- design/bfiq_pkg.sv -----
// Shared definitions for the Bloom filter insert/query block.
// Operation codes, hash constants, default sizes and a width helper.
// No dependencies.
package bfiq_pkg;

  // Default sizes
  localparam int DEF_FILTER_BITS = 4096;
  localparam int DEF_HASH_PROBES = 4;

  // Operation codes on the func field
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // splitmix64 finaliser constants
  localparam logic [63:0] C_GOLDEN  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] C_MIX1    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] C_MIX2    = 64'h94d049bb133111eb;
  // second hash seed
  localparam logic [63:0] C_KEY_XOR = 64'hd6e8feb86659fd93;

  // Address width for a store of the given depth, at least one bit
  function automatic int clog2_min1(input int depth);
    clog2_min1 = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- design/bloom_filter_insert_query_top.sv -----
// Bloom filter over 64-bit keys: insert, query and clear under one sequencer.
// Uses bfiq_pkg, bfiq_hash (shared-multiplier finaliser) and bfiq_ram (bit store).
//
// Usage
//   Input channel: in_func (0 clear, 1 insert, 2 query) and in_key, taken
//   when in_valid is high and in_stall low. Output channel: out_maybe_present
//   and out_keys_inserted, one item for every input item, taken when
//   out_valid is high and out_stall low.
//   One item at a time: in_stall is high from acceptance until the result
//   has been loaded into the output register.
//   Insert or query: two finaliser passes on the one 32x32 multiplier, then
//   per probe 8-bit remainder steps for the word index, a read on the
//   single-port bit store and, for an insert only, a write-back.
//   Clear: zeroes the store one word per cycle, then gives a result.
//   Code 3: a result, nothing changed.
//   Reset: the bit store is swept to zero, one word a cycle, with
//   in_stall high; the count is zeroed.
//   A stalled result holds in the output register; the next item is taken
//   meanwhile and its result waits until the register frees.
module bloom_filter_insert_query_top
  import bfiq_pkg::*;
#(
  parameter int FILTER_BITS = DEF_FILTER_BITS,
  parameter int HASH_PROBES = DEF_HASH_PROBES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_maybe_present,
  output logic [31:0] out_keys_inserted
);

  localparam int NWORDS = (FILTER_BITS + 63) / 64;
  localparam int AW     = clog2_min1(NWORDS);
  localparam int PW     = clog2_min1(HASH_PROBES);
  localparam logic [AW:0]   NWORDS_R = (AW + 1)'(NWORDS);
  localparam logic [AW-1:0] LAST_W   = AW'(NWORDS - 1);
  localparam logic [PW-1:0] LAST_P   = PW'(HASH_PROBES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_H1, S_H2, S_MOD, S_RD, S_CHK, S_PUT
  } state_t;

  state_t        st_r;
  logic [1:0]    func_r;
  logic [63:0]   key_r;
  logic [63:0]   sum_r;
  logic [63:0]   h2_r;
  logic [63:0]   div_sh_r;
  logic [AW:0]   rem_r;
  logic [2:0]    dig_r;
  logic [PW-1:0] probe_r;
  logic [AW-1:0] clr_idx_r;
  logic          clr_op_r;
  logic          hit_r;
  logic [31:0]   count_r;
  logic          out_valid_r;
  logic          out_maybe_r;
  logic [31:0]   out_keys_r;

  logic          in_acc;
  logic          out_load;
  logic          hash_start;
  logic [63:0]   hash_din;
  logic          hash_done;
  logic [63:0]   hash_dout;
  logic [63:0]   div_src;
  logic [AW:0]   rem_step;
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;
  logic [63:0]   bit_mask;

  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // result register takes a new item when empty or being emptied
  assign out_load = (st_r == S_PUT) && (!out_valid_r || !out_stall);

  // hash requests: key on acceptance, seeded key once h1 is in
  assign hash_start = (st_r == S_IDLE && in_acc &&
                       (in_func == FUNC_INSERT || in_func == FUNC_QUERY)) ||
                      (st_r == S_H1 && hash_done);
  assign hash_din   = (st_r == S_H1) ? (key_r ^ C_KEY_XOR) : in_key;

  bfiq_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .din   (hash_din),
    .done  (hash_done),
    .dout  (hash_dout)
  );

  // word index: (sum >> 6) mod NWORDS, eight bits of the dividend per cycle
  always_comb begin
    div_src  = (dig_r == 3'd0) ? {6'd0, sum_r[63:6]} : div_sh_r;
    rem_step = (dig_r == 3'd0) ? '0 : rem_r;
    for (int k = 0; k < 8; k++) begin
      rem_step = {rem_step[AW-1:0], div_src[63-k]};
      if (rem_step >= NWORDS_R) begin
        rem_step = rem_step - NWORDS_R;
      end
    end
  end

  // bit store access: sweep, probe read, insert write-back
  assign bit_mask = 64'd1 << sum_r[5:0];

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rem_r[AW-1:0];
    ram_wdata = ram_rdata | bit_mask;
    unique case (st_r)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_idx_r;
        ram_wdata = '0;
      end
      S_RD: ram_en = 1'b1;
      S_CHK: begin
        ram_en = (func_r == FUNC_INSERT);
        ram_we = (func_r == FUNC_INSERT);
      end
      default: ram_en = 1'b0;
    endcase
  end

  bfiq_ram #(
    .WIDTH (64),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_idx_r   <= '0;
      clr_op_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r <= in_func;
            key_r  <= in_key;
            hit_r  <= 1'b0;
            case (in_func) inside
              FUNC_CLEAR: begin
                count_r   <= '0;
                clr_idx_r <= '0;
                clr_op_r  <= 1'b1;
                st_r      <= S_CLEAR;
              end
              FUNC_INSERT, FUNC_QUERY: st_r <= S_H1;
              default: st_r <= S_PUT;
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_idx_r == LAST_W) begin
            clr_op_r <= 1'b0;
            st_r     <= clr_op_r ? S_PUT : S_IDLE;
          end else begin
            clr_idx_r <= clr_idx_r + AW'(1);
          end
        end
        S_H1: begin
          if (hash_done) begin
            sum_r <= hash_dout;
            st_r  <= S_H2;
          end
        end
        S_H2: begin
          if (hash_done) begin
            h2_r    <= hash_dout | 64'd1;
            probe_r <= '0;
            dig_r   <= 3'd0;
            hit_r   <= (func_r == FUNC_QUERY);
            st_r    <= S_MOD;
          end
        end
        S_MOD: begin
          div_sh_r <= div_src << 8;
          rem_r    <= rem_step;
          dig_r    <= dig_r + 3'd1;
          if (dig_r == 3'd7) begin
            st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_CHK;
        S_CHK: begin
          hit_r <= hit_r & ram_rdata[sum_r[5:0]];
          sum_r <= sum_r + h2_r;
          dig_r <= 3'd0;
          if (probe_r == LAST_P) begin
            if (func_r == FUNC_INSERT && count_r != 32'hFFFF_FFFF) begin
              count_r <= count_r + 32'd1;
            end
            st_r <= S_PUT;
          end else begin
            probe_r <= probe_r + PW'(1);
            st_r    <= S_MOD;
          end
        end
        S_PUT: begin
          if (out_load) begin
            out_maybe_r <= hit_r && (func_r == FUNC_QUERY);
            out_keys_r  <= count_r;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_maybe_r;
  assign out_keys_inserted = out_keys_r;

`ifndef SYNTHESIS
  // a finished hash only arrives while the sequencer waits for one
  a_hash_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (st_r == S_H1 || st_r == S_H2))
    else $error("hash result arrived outside a hash wait");

  // the word index is fully reduced before the store is read
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RD) |-> (rem_r < NWORDS_R))
    else $error("word index not below store depth");

  // the count only steps by one or returns to zero
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == '0 || count_r == $past(count_r) + 32'd1))
    else $error("insert count jumped");

  // a new result is only loaded from the hand-over state
  a_result_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == S_PUT))
    else $error("result loaded outside hand-over");
`endif

endmodule

// ----- design/bfiq_ram.sv -----
// Generic single-port RAM with registered, read-first data.
// Uses bfiq_pkg for the address width helper.
module bfiq_ram
  import bfiq_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic                           we,
  input  logic [clog2_min1(DEPTH)-1:0]   addr,
  input  logic [WIDTH-1:0]               wdata,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one access per cycle; read returns the old word
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/bfiq_hash.sv -----
// splitmix64 finaliser on one shared 32x32 multiplier.
// Each 64-bit product is built from three partial products.
// Uses bfiq_pkg for the mixing constants.
module bfiq_hash
  import bfiq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] din,
  output logic        done,
  output logic [63:0] dout
);

  typedef enum logic [2:0] {H_IDLE, H_MUL0, H_MUL1, H_MUL2, H_MUL3} hstate_t;

  hstate_t     st_r;
  logic        round_r;
  logic        done_r;
  logic [63:0] x_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;
  logic [63:0] dout_r;

  logic [63:0] c_sel;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] v_add;
  logic [31:0] y_hi;
  logic [63:0] y_full;

  // constant for this round
  assign c_sel = round_r ? C_MIX2 : C_MIX1;

  // partial product operands: lo*lo, hi*lo, lo*hi
  always_comb begin
    unique case (st_r)
      H_MUL1:  begin mul_a = x_r[63:32]; mul_b = c_sel[31:0];  end
      H_MUL2:  begin mul_a = x_r[31:0];  mul_b = c_sel[63:32]; end
      default: begin mul_a = x_r[31:0];  mul_b = c_sel[31:0];  end
    endcase
  end

  assign mul_p  = {32'd0, mul_a} * {32'd0, mul_b};
  assign v_add  = din + C_GOLDEN;
  assign y_hi   = acc_r[63:32] + prod_r[31:0];
  assign y_full = {y_hi, acc_r[31:0]};

  // sequencer
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      st_r    <= H_IDLE;
      round_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      // pulse as the second round finishes
      done_r <= (st_r == H_MUL3) && round_r;
      unique case (st_r)
        H_IDLE: begin
          if (start) begin
            x_r     <= v_add ^ (v_add >> 30);
            round_r <= 1'b0;
            st_r    <= H_MUL0;
          end
        end
        H_MUL0: st_r <= H_MUL1;
        H_MUL1: begin
          acc_r <= prod_r;
          st_r  <= H_MUL2;
        end
        H_MUL2: begin
          acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
          st_r         <= H_MUL3;
        end
        H_MUL3: begin
          if (!round_r) begin
            x_r     <= y_full ^ (y_full >> 27);
            round_r <= 1'b1;
            st_r    <= H_MUL0;
          end else begin
            dout_r <= y_full ^ (y_full >> 31);
            st_r   <= H_IDLE;
          end
        end
        default: st_r <= H_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign dout = dout_r;

endmodule

// ----- verif/tb_bloom_filter_insert_query_top.sv -----
// Testbench for bloom_filter_insert_query_top: directed and random clear, insert and query
// traffic, checked against a shadow filter kept in the bench. Random idling is applied on both sides.
// Depends on bfiq_pkg and the block under test only.
module tb_bloom_filter_insert_query_top;
  import bfiq_pkg::*;

  localparam int          STORE_WORDS  = (DEF_FILTER_BITS + 63) / 64;
  localparam logic [63:0] STORE_BITS   = 64'(STORE_WORDS * 64);
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          IDLE_PCT     = 18;

  typedef struct packed {
    logic        hit;
    logic [31:0] count;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_CLEAR;
  logic [63:0] in_key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_maybe_present;
  logic [31:0] out_keys_inserted;

  // shadow copy of the bit store and insert count
  logic [63:0] shadow_words [STORE_WORDS] = '{default: '0};
  logic [31:0] shadow_count = '0;

  result_t     pending_results [$];
  logic [63:0] key_pool [$];
  logic        calm = 1'b0;
  int          err_count = 0;

  bloom_filter_insert_query_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_maybe_present (out_maybe_present),
    .out_keys_inserted (out_keys_inserted)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // splitmix64 finaliser, all arithmetic wraps at 64 bits
  function automatic logic [63:0] mix64(input logic [63:0] v);
    logic [63:0] x;
    x = v + C_GOLDEN;
    x = (x ^ (x >> 30)) * C_MIX1;
    x = (x ^ (x >> 27)) * C_MIX2;
    return x ^ (x >> 31);
  endfunction

  // Apply one operation to the shadow filter and return the result it gives
  function automatic result_t bloom_predict(input logic [1:0] func, input logic [63:0] key);
    result_t     res;
    logic [63:0] h1;
    logic [63:0] h2;
    logic [63:0] bitpos;
    res.hit = 1'b0;
    h1 = mix64(key);
    h2 = mix64(key ^ C_KEY_XOR) | 64'd1;
    case (func)
      FUNC_CLEAR: begin
        for (int w = 0; w < STORE_WORDS; w++) shadow_words[w] = '0;
        shadow_count = '0;
      end
      FUNC_INSERT: begin
        for (int i = 0; i < DEF_HASH_PROBES; i++) begin
          bitpos = (h1 + 64'(i) * h2) % STORE_BITS;
          shadow_words[int'(bitpos >> 6)][bitpos[5:0]] = 1'b1;
        end
        // count saturates
        if (shadow_count != '1) shadow_count = shadow_count + 32'd1;
      end
      FUNC_QUERY: begin
        res.hit = 1'b1;
        for (int i = 0; i < DEF_HASH_PROBES; i++) begin
          bitpos = (h1 + 64'(i) * h2) % STORE_BITS;
          if (!shadow_words[int'(bitpos >> 6)][bitpos[5:0]]) res.hit = 1'b0;
        end
      end
      default: ;
    endcase
    res.count = shadow_count;
    return res;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Present one item, with random idle cycles ahead of it, and record its expected result
  task automatic send_item(input logic [1:0] func, input logic [63:0] key);
    result_t exp_res;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_key   <= key;
    do @(posedge clk); while (in_stall);
    exp_res = bloom_predict(func, key);
    pending_results = {pending_results, exp_res};
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: maybe_present %0b keys_inserted %0d",
               out_maybe_present, out_keys_inserted);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_maybe_present !== exp_res.hit) begin
          $error("maybe_present: expected %0b, got %0b", exp_res.hit, out_maybe_present);
          err_count++;
        end
        if (out_keys_inserted !== exp_res.count) begin
          $error("keys_inserted: expected %0d, got %0d", exp_res.count, out_keys_inserted);
          err_count++;
        end
      end
    end
  end

  // Empty filter straight after reset: misses, and code 3 gives the zero count
  task automatic test_reset_state();
    send_item(FUNC_QUERY, '0);
    send_item(FUNC_UNUSED, 64'h0123_4567_89ab_cdef);
    send_item(FUNC_QUERY, '1);
  endtask

  // Extreme keys go in and are then found; neighbours are looked up too
  task automatic test_extreme_keys();
    send_item(FUNC_INSERT, '0);
    send_item(FUNC_INSERT, '1);
    send_item(FUNC_INSERT, 64'h8000_0000_0000_0000);
    send_item(FUNC_INSERT, 64'h0000_0000_0000_0001);
    send_item(FUNC_QUERY, '0);
    send_item(FUNC_QUERY, '1);
    send_item(FUNC_QUERY, 64'h8000_0000_0000_0000);
    send_item(FUNC_QUERY, 64'h0000_0000_0000_0001);
    send_item(FUNC_QUERY, 64'h0000_0000_0000_0002);
    send_item(FUNC_QUERY, 64'h7fff_ffff_ffff_ffff);
  endtask

  // Unused code leaves store and count alone
  task automatic test_unused_code();
    send_item(FUNC_UNUSED, '1);
    send_item(FUNC_QUERY, '1);
  endtask

  // Clear ignores its key, empties the store and zeroes the count
  task automatic test_clear();
    send_item(FUNC_CLEAR, 64'hdead_beef_cafe_f00d);
    send_item(FUNC_QUERY, '0);
    send_item(FUNC_QUERY, '1);
    send_item(FUNC_INSERT, 64'h5555_5555_5555_5555);
    send_item(FUNC_QUERY, 64'h5555_5555_5555_5555);
    send_item(FUNC_CLEAR, '1);
  endtask

  // Mostly inserts and look-ups of known keys, with misses, clears and unused codes mixed in
  task automatic test_random_traffic();
    logic [63:0] key;
    int unsigned pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 400 && n < 600);
      pick = $urandom_range(99);
      // no clears late on, so the filter fills and false hits can turn up
      if (n >= 700 && pick >= 92 && pick < 96) pick = 40;
      if (pick < 40) begin
        key = rand_key();
        key_pool = {key_pool, key};
        if (key_pool.size() > 256) key_pool.delete(0);
        send_item(FUNC_INSERT, key);
      end else if (pick < 75 && key_pool.size() != 0) begin
        send_item(FUNC_QUERY, key_pool[$urandom_range(key_pool.size() - 1)]);
      end else if (pick < 92) begin
        send_item(FUNC_QUERY, rand_key());
      end else if (pick < 96) begin
        send_item(FUNC_CLEAR, rand_key());
      end else begin
        send_item(FUNC_UNUSED, rand_key());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_extreme_keys();
    test_unused_code();
    test_clear();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
design/bfiq_pkg.sv
design/bfiq_ram.sv
design/bfiq_hash.sv
design/bloom_filter_insert_query_top.sv
verif/tb_bloom_filter_insert_query_top.sv
